// ===== rtl/core/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types, constants and arithmetic for the 5x5 binomial pyramid reduce.
// ----------------------------------------------------------------------------
package gpr_pkg;

   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int SAMPLE_BITS     = 16;
   localparam int NUM_CH          = 3;
   localparam int TAPS            = 5;
   localparam int LINES           = 4;
   localparam int VSUM_BITS       = SAMPLE_BITS + 4;
   localparam int HSUM_BITS       = SAMPLE_BITS + 8;
   localparam int ROW_BITS        = 12;
   localparam int HEIGHT_BITS     = 13;
   localparam int WIDTH_CFG_BITS  = 12;
   localparam int CHAN_CFG_BITS   = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;
   localparam int OUT_ROW_BITS    = 11;
   localparam int OUT_COL_BITS    = 10;
   localparam int MIN_SIZE        = 5;
   localparam int MAX_HEIGHT      = 4096;
   localparam int RESET_WIDTH     = 640;
   localparam int RESET_HEIGHT    = 480;
   localparam int RESET_CHANNELS  = 3;
   localparam int FIRST_CENTER    = 4;
   localparam int CENTER_OFFSET   = 2;
   localparam int ROUND_BIAS      = 128;
   localparam int ROUND_SHIFT     = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } csr_index_type;

   typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0]            pixel_type;
   typedef logic [NUM_CH-1:0][VSUM_BITS-1:0]              vsum_type;
   typedef logic [NUM_CH-1:0][HSUM_BITS-1:0]              hsum_type;
   typedef logic [TAPS-1:0][NUM_CH-1:0][SAMPLE_BITS-1:0]  column_type;
   typedef logic [LINES-1:0][NUM_CH-1:0][SAMPLE_BITS-1:0] lines_type;

   typedef struct packed {
      logic                    valid;
      logic                    emit;
      logic                    last;
      logic [OUT_ROW_BITS-1:0] out_row;
      logic [OUT_COL_BITS-1:0] out_col;
   } meta_type;

   typedef struct packed {
      pixel_type               pixel;
      logic [OUT_ROW_BITS-1:0] out_row;
      logic [OUT_COL_BITS-1:0] out_col;
      logic                    last;
   } result_type;

   // 1-4-6-4-1 over five samples
   function automatic logic [VSUM_BITS-1:0] binom_vert(
      input logic [TAPS-1:0][SAMPLE_BITS-1:0] v
   );
      logic [VSUM_BITS-1:0] outer;
      logic [VSUM_BITS-1:0] inner;
      logic [VSUM_BITS-1:0] mid;
      outer = VSUM_BITS'(v[0]) + VSUM_BITS'(v[4]);
      inner = VSUM_BITS'(v[1]) + VSUM_BITS'(v[3]);
      mid   = VSUM_BITS'(v[2]);
      return outer + (inner << 2) + (mid << 2) + (mid << 1);
   endfunction

   // 1-4-6-4-1 over five vertical sums
   function automatic logic [HSUM_BITS-1:0] binom_horz(
      input logic [TAPS-1:0][VSUM_BITS-1:0] v
   );
      logic [HSUM_BITS-1:0] outer;
      logic [HSUM_BITS-1:0] inner;
      logic [HSUM_BITS-1:0] mid;
      outer = HSUM_BITS'(v[0]) + HSUM_BITS'(v[4]);
      inner = HSUM_BITS'(v[1]) + HSUM_BITS'(v[3]);
      mid   = HSUM_BITS'(v[2]);
      return outer + (inner << 2) + (mid << 2) + (mid << 1);
   endfunction

   // (sum + 128) >> 8; cannot overflow since the sum is at most 256 * full scale
   function automatic logic [SAMPLE_BITS-1:0] round_div256(
      input logic [HSUM_BITS-1:0] s
   );
      logic [HSUM_BITS-1:0] biased;
      biased = s + HSUM_BITS'(ROUND_BIAS);
      return biased[HSUM_BITS-1:ROUND_SHIFT];
   endfunction

endpackage

// ===== rtl/core/gpr_req_if.sv =====
// ----------------------------------------------------------------------------
// gpr_req_if
// Input pixel channel: valid/ready with three samples per word.
// ----------------------------------------------------------------------------
interface gpr_req_if;
   logic                           valid;
   logic                           ready;
   logic [gpr_pkg::SAMPLE_BITS-1:0] sample_ch0;
   logic [gpr_pkg::SAMPLE_BITS-1:0] sample_ch1;
   logic [gpr_pkg::SAMPLE_BITS-1:0] sample_ch2;

   modport source (output valid, output sample_ch0, output sample_ch1,
                   output sample_ch2, input ready);
   modport sink   (input valid, input sample_ch0, input sample_ch1,
                   input sample_ch2, output ready);
   modport monitor(input valid, input sample_ch0, input sample_ch1,
                   input sample_ch2, input ready);
endinterface

// ===== rtl/core/gpr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gpr_rsp_if
// Result channel: valid/ready with filtered samples and reduced coordinates.
// ----------------------------------------------------------------------------
interface gpr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [gpr_pkg::SAMPLE_BITS-1:0]  filtered_ch0;
   logic [gpr_pkg::SAMPLE_BITS-1:0]  filtered_ch1;
   logic [gpr_pkg::SAMPLE_BITS-1:0]  filtered_ch2;
   logic [gpr_pkg::OUT_ROW_BITS-1:0] out_row;
   logic [gpr_pkg::OUT_COL_BITS-1:0] out_col;
   logic                             frame_last;

   modport source (output valid, output filtered_ch0, output filtered_ch1,
                   output filtered_ch2, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input filtered_ch0, input filtered_ch1,
                   input filtered_ch2, input out_row, input out_col,
                   input frame_last, output ready);
   modport monitor(input valid, input filtered_ch0, input filtered_ch1,
                   input filtered_ch2, input out_row, input out_col,
                   input frame_last, input ready);
endinterface

// ===== rtl/core/gpr_scan.sv =====
// ----------------------------------------------------------------------------
// gpr_scan
// Frame registers, raster position counters and per-word output tagging.
// ----------------------------------------------------------------------------
module gpr_scan #(
   parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [gpr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gpr_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                 fire,
   input  logic                                 en,
   output logic [$clog2(MAX_WIDTH)-1:0]         col_addr,
   output gpr_pkg::meta_type                    s1,
   output logic [gpr_pkg::CHAN_CFG_BITS-1:0]    channel_count
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WB = (COL_BITS + 1 > gpr_pkg::WIDTH_CFG_BITS) ?
                       COL_BITS + 1 : gpr_pkg::WIDTH_CFG_BITS;
   localparam int OB = (COL_BITS - 1 > gpr_pkg::OUT_COL_BITS) ?
                       COL_BITS - 1 : gpr_pkg::OUT_COL_BITS;
   localparam int HB = gpr_pkg::HEIGHT_BITS;
   localparam int RESET_W = (gpr_pkg::RESET_WIDTH > MAX_WIDTH) ?
                            MAX_WIDTH : gpr_pkg::RESET_WIDTH;
   localparam logic [WB-1:0] MAX_W = WB'(MAX_WIDTH);
   localparam logic [WB-1:0] MIN_W = WB'(gpr_pkg::MIN_SIZE);
   localparam logic [HB-1:0] MAX_H = HB'(gpr_pkg::MAX_HEIGHT);
   localparam logic [HB-1:0] MIN_H = HB'(gpr_pkg::MIN_SIZE);

   logic [WB-1:0]                        width_ff;
   logic [HB-1:0]                        height_ff;
   logic [gpr_pkg::CHAN_CFG_BITS-1:0]    chan_ff;
   logic [COL_BITS-1:0]                  col_ff;
   logic [gpr_pkg::ROW_BITS-1:0]         row_ff;
   gpr_pkg::meta_type                    s1_ff;
   gpr_pkg::meta_type                    s1_in;

   logic [WB-1:0]  wr_width;
   logic [HB-1:0]  wr_height;
   logic           cfg_hit;
   logic [WB-1:0]  col_next;
   logic [HB-1:0]  row_next;
   logic [OB-1:0]  half_col;

   always_comb begin
      wr_width  = WB'(csr_wdata[gpr_pkg::WIDTH_CFG_BITS-1:0]);
      wr_height = csr_wdata[HB-1:0];
      if (wr_width < MIN_W) begin
         wr_width = MIN_W;
      end else if (wr_width > MAX_W) begin
         wr_width = MAX_W;
      end
      if (wr_height < MIN_H) begin
         wr_height = MIN_H;
      end else if (wr_height > MAX_H) begin
         wr_height = MAX_H;
      end
      unique case (gpr_pkg::csr_index_type'(csr_index))
         gpr_pkg::CSR_FRAME_WIDTH,
         gpr_pkg::CSR_FRAME_HEIGHT,
         gpr_pkg::CSR_CHANNEL_COUNT: cfg_hit = csr_we;
         default:                    cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(RESET_W);
         height_ff <= HB'(gpr_pkg::RESET_HEIGHT);
         chan_ff   <= gpr_pkg::CHAN_CFG_BITS'(gpr_pkg::RESET_CHANNELS);
      end else if (csr_we) begin
         unique case (gpr_pkg::csr_index_type'(csr_index))
            gpr_pkg::CSR_FRAME_WIDTH:   width_ff  <= wr_width;
            gpr_pkg::CSR_FRAME_HEIGHT:  height_ff <= wr_height;
            gpr_pkg::CSR_CHANNEL_COUNT:
               chan_ff <= csr_wdata[gpr_pkg::CHAN_CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign col_next = WB'(col_ff) + WB'(1);
   assign row_next = HB'(row_ff) + HB'(1);

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (fire) begin
         if (col_next == width_ff) begin
            col_ff <= '0;
            row_ff <= (row_next == height_ff) ? '0 : row_next[gpr_pkg::ROW_BITS-1:0];
         end else begin
            col_ff <= col_next[COL_BITS-1:0];
         end
      end
   end

   assign half_col = OB'(col_ff[COL_BITS-1:1]) - OB'(gpr_pkg::CENTER_OFFSET);

   always_comb begin
      s1_in.valid   = fire;
      s1_in.emit    = (row_ff >= gpr_pkg::ROW_BITS'(gpr_pkg::FIRST_CENTER)) &&
                      (col_ff >= COL_BITS'(gpr_pkg::FIRST_CENTER)) &&
                      !row_ff[0] && !col_ff[0];
      s1_in.last    = (HB'(row_ff) + HB'(gpr_pkg::CENTER_OFFSET) >= height_ff) &&
                      (WB'(col_ff) + WB'(gpr_pkg::CENTER_OFFSET) >= width_ff);
      s1_in.out_row = row_ff[gpr_pkg::ROW_BITS-1:1] -
                      gpr_pkg::OUT_ROW_BITS'(gpr_pkg::CENTER_OFFSET);
      s1_in.out_col = half_col[gpr_pkg::OUT_COL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
   end

   assign col_addr      = col_ff;
   assign s1            = s1_ff;
   assign channel_count = chan_ff;

endmodule

// ===== rtl/core/gpr_line_mem.sv =====
// ----------------------------------------------------------------------------
// gpr_line_mem
// Four-line column store: read at accept, write the shifted column back as the
// pipeline advances. Successive words hit different columns within a frame.
// ----------------------------------------------------------------------------
module gpr_line_mem #(
   parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          fire,
   input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
   input  gpr_pkg::pixel_type            sample_in,
   input  logic                          wr_en,
   output gpr_pkg::column_type           column
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   gpr_pkg::lines_type           mem [MAX_WIDTH];
   gpr_pkg::lines_type           rd_ff;
   gpr_pkg::pixel_type           pix_ff;
   logic [COL_BITS-1:0]          addr_ff;
   gpr_pkg::lines_type           lines_in;

   always_comb begin
      for (int r = 0; r < gpr_pkg::LINES; r++) begin
         column[r] = rd_ff[r];
      end
      column[gpr_pkg::LINES] = pix_ff;
      for (int r = 0; r < gpr_pkg::LINES - 1; r++) begin
         lines_in[r] = rd_ff[r+1];
      end
      lines_in[gpr_pkg::LINES-1] = pix_ff;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rd_ff   <= mem[addr];
         pix_ff  <= sample_in;
         addr_ff <= addr;
      end
      if (wr_en) begin
         mem[addr_ff] <= lines_in;
      end
   end

endmodule

// ===== rtl/core/gpr_filter.sv =====
// ----------------------------------------------------------------------------
// gpr_filter
// Vertical 1-4-6-4-1 per column, five-deep column-sum window, horizontal
// 1-4-6-4-1 and rounding, with unused channels forced to zero.
// ----------------------------------------------------------------------------
module gpr_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  gpr_pkg::meta_type                 s1,
   input  gpr_pkg::column_type               column,
   input  logic [gpr_pkg::CHAN_CFG_BITS-1:0] channel_count,
   output logic                              out_valid,
   output gpr_pkg::result_type               out_item
);

   gpr_pkg::vsum_type [gpr_pkg::TAPS-1:0] vwin_ff;
   gpr_pkg::vsum_type [gpr_pkg::TAPS-1:0] vwin_in;
   gpr_pkg::vsum_type                     vnew;
   gpr_pkg::hsum_type                     hsum_ff;
   gpr_pkg::hsum_type                     hsum_in;
   gpr_pkg::meta_type                     s2_ff;
   gpr_pkg::meta_type                     s3_ff;
   gpr_pkg::meta_type                     s3_in;

   logic [gpr_pkg::TAPS-1:0][gpr_pkg::SAMPLE_BITS-1:0] vtaps;
   logic [gpr_pkg::TAPS-1:0][gpr_pkg::VSUM_BITS-1:0]   htaps;

   always_comb begin
      for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++) begin
         for (int r = 0; r < gpr_pkg::TAPS; r++) begin
            vtaps[r] = column[r][ch];
         end
         vnew[ch] = gpr_pkg::binom_vert(vtaps);
      end
      for (int c = 0; c < gpr_pkg::TAPS - 1; c++) begin
         vwin_in[c] = vwin_ff[c+1];
      end
      vwin_in[gpr_pkg::TAPS-1] = vnew;
   end

   always_comb begin
      for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++) begin
         for (int c = 0; c < gpr_pkg::TAPS; c++) begin
            htaps[c] = vwin_ff[c][ch];
         end
         hsum_in[ch] = gpr_pkg::binom_horz(htaps);
      end
      s3_in       = s2_ff;
      s3_in.valid = s2_ff.valid && s2_ff.emit;
   end

   always_ff @(posedge clock) begin
      if (en && s1.valid) begin
         vwin_ff <= vwin_in;
      end
      if (en) begin
         hsum_ff <= hsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
         s3_ff <= '0;
      end else if (en) begin
         s2_ff <= s1;
         s3_ff <= s3_in;
      end
   end

   always_comb begin
      for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++) begin
         out_item.pixel[ch] = (gpr_pkg::CHAN_CFG_BITS'(ch) < channel_count) ?
                              gpr_pkg::round_div256(hsum_ff[ch]) : '0;
      end
      out_item.out_row = s3_ff.out_row;
      out_item.out_col = s3_ff.out_col;
      out_item.last    = s3_ff.last;
   end

   assign out_valid = s3_ff.valid;

endmodule

// ===== rtl/core/gpr_out_skid.sv =====
// ----------------------------------------------------------------------------
// gpr_out_skid
// Output register plus skid register; pipeline advance depends only on the
// skid flop, so upstream ready is registered.
// ----------------------------------------------------------------------------
module gpr_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  gpr_pkg::result_type  in_item,
   output logic                 en,
   gpr_rsp_if.source            rsp_chan
);

   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   gpr_pkg::result_type  out_item_ff;
   gpr_pkg::result_type  skid_item_ff;
   logic                 take;

   assign take = !out_valid_ff || rsp_chan.ready;
   assign en   = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff  <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_item_ff <= skid_valid_ff ? skid_item_ff : in_item;
      end else if (in_valid) begin
         skid_item_ff <= in_item;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.filtered_ch0 = out_item_ff.pixel[0];
   assign rsp_chan.filtered_ch1 = out_item_ff.pixel[1];
   assign rsp_chan.filtered_ch2 = out_item_ff.pixel[2];
   assign rsp_chan.out_row      = out_item_ff.out_row;
   assign rsp_chan.out_col      = out_item_ff.out_col;
   assign rsp_chan.frame_last   = out_item_ff.last;

endmodule

// ===== rtl/core/gaussian_pyramid_reduce_5x5_core.sv =====
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_5x5_core
// 5x5 binomial filter and 2:1 decimation of a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock unless the output stalls, and gives one
// filtered word for each even row and column centre at least two pixels in
// from the border. A result moves through the read, window, horizontal-sum
// and output registers. The rate is set by the line memory: each accepted word
// does one read of its column's four stored lines at accept and one write-back
// of the shifted column as the pipeline advances, one port of each per cycle.
// req ready drops only while both the output register and the skid register
// hold words. The line memory needs no clearing pass after reset: a column is
// read into a result only after the four preceding rows of the current frame
// wrote it. Any write to a defined register restarts the frame.
// ----------------------------------------------------------------------------
module gaussian_pyramid_reduce_5x5_core #(
   parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gpr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gpr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   gpr_req_if.sink                            req_chan,
   gpr_rsp_if.source                          rsp_chan
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   logic                              en;
   logic                              fire;
   logic [COL_BITS-1:0]               col_addr;
   gpr_pkg::meta_type                 s1;
   logic [gpr_pkg::CHAN_CFG_BITS-1:0] channel_count;
   gpr_pkg::pixel_type                sample_in;
   gpr_pkg::column_type               column;
   logic                              res_valid;
   gpr_pkg::result_type               res_item;

   assign fire           = req_chan.valid && en;
   assign req_chan.ready = en;
   assign sample_in[0]   = req_chan.sample_ch0;
   assign sample_in[1]   = req_chan.sample_ch1;
   assign sample_in[2]   = req_chan.sample_ch2;

   gpr_scan #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fire          (fire),
      .en            (en),
      .col_addr      (col_addr),
      .s1            (s1),
      .channel_count (channel_count)
   );

   gpr_line_mem #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line_mem (
      .clock     (clock),
      .fire      (fire),
      .addr      (col_addr),
      .sample_in (sample_in),
      .wr_en     (en && s1.valid),
      .column    (column)
   );

   gpr_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .s1            (s1),
      .column        (column),
      .channel_count (channel_count),
      .out_valid     (res_valid),
      .out_item      (res_item)
   );

   gpr_out_skid u_out_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid && en),
      .in_item  (res_item),
      .en       (en),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/core/gpr_checker.sv =====
// ----------------------------------------------------------------------------
// gpr_checker
// Port-level checks for the pyramid reduce core, bound to the top level.
// ----------------------------------------------------------------------------
module gpr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [gpr_pkg::SAMPLE_BITS-1:0]  rsp_filtered_ch0,
   input  logic [gpr_pkg::SAMPLE_BITS-1:0]  rsp_filtered_ch1,
   input  logic [gpr_pkg::SAMPLE_BITS-1:0]  rsp_filtered_ch2,
   input  logic [gpr_pkg::OUT_ROW_BITS-1:0] rsp_out_row,
   input  logic [gpr_pkg::OUT_COL_BITS-1:0] rsp_out_col,
   input  logic                             rsp_frame_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_filtered_ch0) && $stable(rsp_filtered_ch1) &&
         $stable(rsp_filtered_ch2) && $stable(rsp_out_row) &&
         $stable(rsp_out_col) && $stable(rsp_frame_last))
      else $error("result word changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with output empty");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not cleared by reset");

endmodule

bind gaussian_pyramid_reduce_5x5_core gpr_checker u_gpr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_filtered_ch0 (rsp_chan.filtered_ch0),
   .rsp_filtered_ch1 (rsp_chan.filtered_ch1),
   .rsp_filtered_ch2 (rsp_chan.filtered_ch2),
   .rsp_out_row      (rsp_chan.out_row),
   .rsp_out_col      (rsp_chan.out_col),
   .rsp_frame_last   (rsp_chan.frame_last)
);

// ===== verif/gaussian_pyramid_reduce_5x5_core_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_5x5_core_tb
// Drives pixel frames of many shapes and channel counts through the 5x5
// binomial reduce, predicts every reduced word from its own line store and
// window, and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module gaussian_pyramid_reduce_5x5_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [gpr_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_ITEMS  = 450;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_LIMIT  = 60;
   localparam int TIMEOUT_NS    = 2_000_000;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   // reduced-pixel predictor and in-order store of expected words
   class reduced_pixel_tracker;
      int unsigned width_reg;
      int unsigned height_reg;
      int unsigned chan_reg;
      int unsigned row_pos;
      int unsigned col_pos;
      bit [gpr_pkg::SAMPLE_BITS-1:0]
         line_mem [gpr_pkg::MAX_WIDTH_DEF][gpr_pkg::LINES][gpr_pkg::NUM_CH];
      bit [gpr_pkg::SAMPLE_BITS-1:0]
         window [gpr_pkg::TAPS][gpr_pkg::TAPS][gpr_pkg::NUM_CH];
      int unsigned binom [gpr_pkg::TAPS] = '{1, 4, 6, 4, 1};
      gpr_pkg::result_type expected_reduced [$];
      int mismatches;

      function new();
         width_reg  = gpr_pkg::RESET_WIDTH;
         height_reg = gpr_pkg::RESET_HEIGHT;
         chan_reg   = gpr_pkg::RESET_CHANNELS;
         row_pos    = 0;
         col_pos    = 0;
         mismatches = 0;
      endfunction

      function int unsigned fit(int unsigned v, int unsigned lo, int unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_register(logic [gpr_pkg::CSR_INDEX_BITS-1:0] idx,
                                   logic [gpr_pkg::CSR_DATA_BITS-1:0] value);
         bit hit;
         hit = 1'b1;
         case (idx)
            gpr_pkg::CSR_FRAME_WIDTH:
               width_reg  = 32'(value[gpr_pkg::WIDTH_CFG_BITS-1:0]);
            gpr_pkg::CSR_FRAME_HEIGHT:
               height_reg = 32'(value[gpr_pkg::HEIGHT_BITS-1:0]);
            gpr_pkg::CSR_CHANNEL_COUNT:
               chan_reg   = 32'(value[gpr_pkg::CHAN_CFG_BITS-1:0]);
            default: hit = 1'b0;
         endcase
         if (hit) begin
            row_pos = 0;
            col_pos = 0;
         end
      endfunction

      function void take_pixel(gpr_pkg::pixel_type px);
         int unsigned w;
         int unsigned h;
         int unsigned row;
         int unsigned col;
         bit [gpr_pkg::SAMPLE_BITS-1:0] fresh [gpr_pkg::TAPS][gpr_pkg::NUM_CH];
         longint unsigned acc;
         gpr_pkg::result_type want;
         w = fit(width_reg, gpr_pkg::MIN_SIZE, gpr_pkg::MAX_WIDTH_DEF);
         h = fit(height_reg, gpr_pkg::MIN_SIZE, gpr_pkg::MAX_HEIGHT);
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;
         row = row_pos;
         col = col_pos;
         for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++) begin
            for (int r = 0; r < gpr_pkg::LINES; r++) fresh[r][ch] = line_mem[col][r][ch];
            fresh[gpr_pkg::LINES][ch] = px[ch];
            for (int r = 0; r < gpr_pkg::LINES; r++) line_mem[col][r][ch] = fresh[r+1][ch];
         end
         for (int r = 0; r < gpr_pkg::TAPS; r++) begin
            for (int c = 0; c < gpr_pkg::TAPS - 1; c++)
               for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++)
                  window[r][c][ch] = window[r][c+1][ch];
            for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++)
               window[r][gpr_pkg::TAPS-1][ch] = fresh[r][ch];
         end
         if (row >= gpr_pkg::FIRST_CENTER && col >= gpr_pkg::FIRST_CENTER &&
             row % 2 == 0 && col % 2 == 0) begin
            for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++) begin
               acc = 0;
               if (ch < chan_reg) begin
                  for (int r = 0; r < gpr_pkg::TAPS; r++)
                     for (int c = 0; c < gpr_pkg::TAPS; c++)
                        acc += binom[r] * binom[c] * window[r][c][ch];
                  acc = (acc + gpr_pkg::ROUND_BIAS) >> gpr_pkg::ROUND_SHIFT;
               end
               want.pixel[ch] = gpr_pkg::SAMPLE_BITS'(acc);
            end
            want.out_row = gpr_pkg::OUT_ROW_BITS'((row - gpr_pkg::FIRST_CENTER) >> 1);
            want.out_col = gpr_pkg::OUT_COL_BITS'((col - gpr_pkg::FIRST_CENTER) >> 1);
            want.last    = (row + gpr_pkg::CENTER_OFFSET >= h) &&
                           (col + gpr_pkg::CENTER_OFFSET >= w);
            expected_reduced.push_back(want);
         end
         col_pos = col + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void note_mismatch(string what, longint unsigned want_v,
                                  longint unsigned got_v);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: %s expected %0h actual %0h", $time, what, want_v, got_v);
      endfunction

      function void check_reduced(gpr_pkg::result_type got);
         gpr_pkg::result_type want;
         if (expected_reduced.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t ns: word with no prediction, row %0d col %0d",
                        $time, got.out_row, got.out_col);
            return;
         end
         want = expected_reduced.pop_front();
         for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++)
            if (got.pixel[ch] !== want.pixel[ch])
               note_mismatch($sformatf("filtered_ch%0d", ch), want.pixel[ch], got.pixel[ch]);
         if (got.out_row !== want.out_row) note_mismatch("out_row", want.out_row, got.out_row);
         if (got.out_col !== want.out_col) note_mismatch("out_col", want.out_col, got.out_col);
         if (got.last !== want.last) note_mismatch("frame_last", want.last, got.last);
      endfunction

      function int outstanding();
         return expected_reduced.size();
      endfunction

      function void report_leftover();
         if (expected_reduced.size() != 0) begin
            $display("%0t ns: %0d predicted words never arrived", $time,
                     expected_reduced.size());
            mismatches += expected_reduced.size();
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [gpr_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [gpr_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   gpr_req_if req_if();
   gpr_rsp_if rsp_if();

   gaussian_pyramid_reduce_5x5_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   reduced_pixel_tracker tracker = new;

   int burst_left    = 0;
   bit gapless       = 1'b0;
   bit hold_request  = 1'b0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("gaussian_pyramid_reduce_5x5_core: mismatch");
      $finish;
   end

   // receiver: random stall patterns, plus a long hold-off on request
   initial begin : receiver
      rx_mode_type mode;
      int run_left;
      int hold_left;
      mode      = RX_OPEN;
      run_left  = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               mode     = rx_mode_type'($urandom_range(0, 3));
               run_left = $urandom_range(10, 150);
            end
            run_left--;
            case (mode)
               RX_OPEN:   rsp_if.ready <= 1'b1;
               RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_if.ready <= (run_left % 4 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      gpr_pkg::result_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.pixel[0] = rsp_if.filtered_ch0;
         got.pixel[1] = rsp_if.filtered_ch1;
         got.pixel[2] = rsp_if.filtered_ch2;
         got.out_row  = rsp_if.out_row;
         got.out_col  = rsp_if.out_col;
         got.last     = rsp_if.frame_last;
         tracker.check_reduced(got);
      end
   end

   function automatic gpr_pkg::pixel_type random_pixel();
      gpr_pkg::pixel_type px;
      case ($urandom_range(0, 9))
         0:       px = '1;
         1:       px = '0;
         2: begin
            for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++)
               px[ch] = {gpr_pkg::SAMPLE_BITS{1'($urandom_range(0, 1))}};
         end
         default: begin
            for (int ch = 0; ch < gpr_pkg::NUM_CH; ch++)
               px[ch] = gpr_pkg::SAMPLE_BITS'($urandom);
         end
      endcase
      return px;
   endfunction

   task automatic offer_pixel(input gpr_pkg::pixel_type px);
      int gap;
      req_if.valid      <= 1'b1;
      req_if.sample_ch0 <= px[0];
      req_if.sample_ch1 <= px[1];
      req_if.sample_ch2 <= px[2];
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      tracker.take_pixel(px);
      if (!gapless) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(1, 10);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_pixels(input int count);
      for (int i = 0; i < count; i++) offer_pixel(random_pixel());
      req_if.valid <= 1'b0;
   endtask

   task automatic settle();
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [gpr_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [gpr_pkg::CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int ch);
      settle();
      write_register(gpr_pkg::CSR_FRAME_WIDTH, gpr_pkg::CSR_DATA_BITS'(w));
      write_register(gpr_pkg::CSR_FRAME_HEIGHT, gpr_pkg::CSR_DATA_BITS'(h));
      write_register(gpr_pkg::CSR_CHANNEL_COUNT, gpr_pkg::CSR_DATA_BITS'(ch));
   endtask

   initial begin : stimulus
      gpr_pkg::pixel_type px;
      int w;
      int h;
      int ch;
      int count;
      int part;
      int random_items;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.sample_ch0 <= '0;
      req_if.sample_ch1 <= '0;
      req_if.sample_ch2 <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame: full scale, lone centre spike, alternating extremes
      configure(5, 5, 3);
      for (int i = 0; i < 25; i++) begin
         px[0] = '1;
         px[1] = (i == 12) ? '1 : '0;
         px[2] = (i % 2 != 0) ? 16'hFFFF : 16'h0001;
         offer_pixel(px);
      end
      req_if.valid <= 1'b0;

      configure(8, 8, 3);
      send_pixels(128);
      configure(6, 7, 1);
      send_pixels(84);
      // sizes below range clamp to five, no channels in use
      configure(0, 0, 0);
      send_pixels(50);
      configure(9, 6, 2);
      send_pixels(162);

      // receiver holds off while the sender keeps offering
      configure(12, 10, 3);
      hold_request = 1'b1;
      gapless      = 1'b1;
      send_pixels(240);
      gapless      = 1'b0;

      // drain mid-frame, write the spare index, frame carries on
      configure(7, 9, 3);
      send_pixels(30);
      settle();
      write_register(CSR_SPARE, gpr_pkg::CSR_DATA_BITS'($urandom));
      send_pixels(96);

      // out-of-range width and height, partial frames
      configure(13'h1FFF, 5, 3);
      send_pixels(150);
      configure(5, 8191, 2);
      send_pixels(150);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 4);
            1, 2:    w = $urandom_range(17, 48);
            default: w = $urandom_range(5, 16);
         endcase
         case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, 4);
            1:       h = $urandom_range(13, 24);
            default: h = $urandom_range(5, 12);
         endcase
         ch = $urandom_range(0, 3);
         configure(w, h, ch);
         count = ((w < gpr_pkg::MIN_SIZE) ? gpr_pkg::MIN_SIZE : w) *
                 ((h < gpr_pkg::MIN_SIZE) ? gpr_pkg::MIN_SIZE : h) * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         if (count > 1 && $urandom_range(0, 5) == 0) begin
            part = $urandom_range(1, count - 1);
            send_pixels(part);
            settle();
            write_register(CSR_SPARE, gpr_pkg::CSR_DATA_BITS'($urandom));
            send_pixels(count - part);
         end else begin
            send_pixels(count);
         end
         random_items += count;
      end

      settle();
      tracker.report_leftover();
      if (tracker.mismatches == 0) begin
         $display("gaussian_pyramid_reduce_5x5_core: match");
      end else begin
         $display("gaussian_pyramid_reduce_5x5_core: mismatch");
      end
      $finish;
   end

endmodule
